// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// shared widths, opcode and status codes, and the command type passed from
// the front part of the deque to its back part
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEF_DEPTH      = 16;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd3;

  typedef enum logic [2:0] {
    K_PUSH_FRONT,
    K_PUSH_BACK,
    K_POP_FRONT,
    K_POP_BACK,
    K_DUMP,
    K_INVALID
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

endpackage

// ===== rtl/deq_if.sv =====
// ----------------------------------------------------------------------------
// deq_in_if / deq_out_if
// valid/ready channels for operation beats and result beats
// ----------------------------------------------------------------------------
interface deq_in_if;
  import deq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_out;
  logic [ST_W-1:0]         status;
  logic                    last;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, output value_out, output status, output last,
                  output occupancy, input ready);
  modport sink   (input valid, input value_out, input status, input last,
                  input occupancy, output ready);
endinterface

// ===== rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/deq_front.sv =====
// ----------------------------------------------------------------------------
// deq_front
// accepts operation beats, decodes the opcode and holds the decoded
// commands in a two-entry queue for the back part
// ----------------------------------------------------------------------------
module deq_front (
  input  logic           clk,
  input  logic           rst_n,
  deq_in_if.sink         in_ch,
  output logic           cmd_valid,
  output deq_pkg::cmd_t  cmd,
  input  logic           cmd_take
);
  import deq_pkg::*;

  cmd_t       q_mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc;
  cmd_t       dec;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign acc         = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_mem_r[rp_r];

  always_comb begin
    dec.value = in_ch.item_value;
    case (in_ch.opcode)
      OP_PUSH_FRONT: dec.kind = K_PUSH_FRONT;
      OP_PUSH_BACK:  dec.kind = K_PUSH_BACK;
      OP_POP_FRONT:  dec.kind = K_POP_FRONT;
      OP_POP_BACK:   dec.kind = K_POP_BACK;
      OP_DUMP:       dec.kind = K_DUMP;
      default:       dec.kind = K_INVALID;
    endcase
  end

  always_comb begin
    wp_nxt  = acc ? ~wp_r : wp_r;
    rp_nxt  = cmd_take ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, cmd_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (acc) begin
      q_mem_r[wp_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n && cmd_take && !cmd_valid) begin
      $error("command taken from an empty queue");
    end
  end

endmodule

// ===== rtl/deq_back.sv =====
// ----------------------------------------------------------------------------
// deq_back
// carries out decoded commands on the ring store: head index, word count,
// ram access and the registered result beat
// ----------------------------------------------------------------------------
module deq_back #(
  parameter int DEPTH      = deq_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  deq_pkg::cmd_t  cmd,
  output logic           cmd_take,
  deq_out_if.source      out_ch
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_DUMP_REQ, S_DUMP_DATA} state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [ST_W-1:0]         out_st_r, out_st_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [OCC_W-1:0]        out_occ_r, out_occ_nxt;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0]   ram_wdata, ram_rdata;

  logic                    out_free;
  logic                    is_full, is_empty;
  logic [VAL_W+DATA_WIDTH-1:0] wdata_ext;
  logic [DATA_WIDTH+VAL_W-1:0] rdata_ext;
  logic [VAL_W-1:0]        rdata_val;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] h, logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, off};
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] occ_of(logic [CW-1:0] c);
    logic [CW+OCC_W-1:0] e;
    e = {{OCC_W{1'b0}}, c};
    return e[OCC_W-1:0];
  endfunction

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign wdata_ext = {{DATA_WIDTH{cmd.value[VAL_W-1]}}, cmd.value};
  assign ram_wdata = wdata_ext[DATA_WIDTH-1:0];
  assign rdata_ext = {{VAL_W{ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
  assign rdata_val = rdata_ext[VAL_W-1:0];

  assign out_free = !out_valid_r || out_ch.ready;
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = out_val_r;
  assign out_ch.status    = out_st_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.occupancy = out_occ_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    out_occ_nxt   = out_occ_r;
    cmd_take      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_re        = 1'b0;
    ram_raddr     = head_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take      = 1'b1;
          out_valid_nxt = 1'b1;
          out_val_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_st_nxt    = ST_OK;
          out_occ_nxt   = occ_of(count_r);
          case (cmd.kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
              if (is_full) begin
                out_st_nxt = ST_FULL;
              end else begin
                ram_we      = 1'b1;
                count_nxt   = count_r + CW'(1);
                out_occ_nxt = occ_of(count_r + CW'(1));
                if (cmd.kind == K_PUSH_FRONT) begin
                  head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
                  ram_waddr = head_nxt;
                end else begin
                  ram_waddr = wrap_add(head_r, count_r);
                end
              end
            end
            K_POP_FRONT, K_POP_BACK: begin
              if (is_empty) begin
                out_st_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                ram_re        = 1'b1;
                count_nxt     = count_r - CW'(1);
                state_nxt     = S_POP;
                if (cmd.kind == K_POP_FRONT) begin
                  ram_raddr = head_r;
                  head_nxt  = wrap_add(head_r, CW'(1));
                end else begin
                  ram_raddr = wrap_add(head_r, count_r - CW'(1));
                end
                if (count_r == CW'(1)) begin
                  head_nxt = '0;
                end
              end
            end
            K_DUMP: begin
              if (is_empty) begin
                out_st_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                ram_re        = 1'b1;
                ram_raddr     = head_r;
                idx_nxt       = '0;
                state_nxt     = S_DUMP_DATA;
              end
            end
            default: begin
              out_st_nxt = ST_INVALID;
            end
          endcase
        end
      end
      S_POP: begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = rdata_val;
        out_st_nxt    = ST_OK;
        out_last_nxt  = 1'b1;
        out_occ_nxt   = occ_of(count_r);
        state_nxt     = S_IDLE;
      end
      S_DUMP_REQ: begin
        if (out_free) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head_r, idx_r);
          state_nxt = S_DUMP_DATA;
        end
      end
      S_DUMP_DATA: begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = rdata_val;
        out_st_nxt    = ST_OK;
        out_last_nxt  = (idx_r + CW'(1) == count_r);
        out_occ_nxt   = occ_of(count_r);
        if (idx_r + CW'(1) == count_r) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_DUMP_REQ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("word count above depth");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < AW'(DEPTH) || DEPTH == (1 << AW))
    else $error("head index out of ring");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == '0)
    else $error("empty queue with nonzero head");

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP || state_r == S_DUMP_DATA) |-> !out_valid_r)
    else $error("read data arrives while result slot is busy");

  a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP_REQ || state_r == S_DUMP_DATA) |-> idx_r < count_r)
    else $error("dump index past stored words");

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded double-ended queue of signed words in a ring store
// ----------------------------------------------------------------------------
// in_ch carries one operation per beat: opcode and item_value. out_ch
// carries result beats: value_out, status, last and occupancy. every
// operation gives one result beat with last set; a dump of a non-empty
// queue gives one beat per stored word, front to back, last on the back.
// a beat enters a two-entry command queue, the back part takes it once the
// result register is free, and the result is registered; a pop or dump
// of a non-empty queue also waits on a registered ram read. pushes and
// other non-reading commands run one per cycle while out_ch is ready; a pop
// is a ram read then a result load, a dump a ram read then a result load
// per stored word; neither lets the back part take a new command meanwhile.
// when out_ch stalls the result register holds, the back part waits, and
// in_ch keeps accepting until the command queue holds two beats.
// reset (rst_n low, synchronous) empties the queue and drops any pending
// commands and results; the ram needs no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int DEPTH      = deq_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch
);
  import deq_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  deq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  deq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for double_ended_queue_unit: a mirror of the deque
// tracks ring store, head and count for each accepted operation beat and
// queues the result beats it implies; every result beat is compared field
// by field. directed corner cases come first, then random runs that lean
// toward filling, draining or mixing, under three sender/receiver idle
// mixes, with a long receiver hold-off and drain pauses in between
// ----------------------------------------------------------------------------
module tb;
  import deq_pkg::*;

  localparam int Q_DEPTH    = DEF_DEPTH;
  localparam int IDX_W      = $clog2(Q_DEPTH);
  localparam int RUN_LIMIT  = 500000;
  localparam int TAIL_WAIT  = 40;
  localparam int HOLD_LEN   = 80;
  localparam int PHASE_OPS  = 62;
  localparam int BURST_OPS  = 20;
  localparam int MAX_PRINTS = 40;

  localparam logic [OP_W-1:0] OP_BAD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} run_mode_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [ST_W-1:0]         status;
    logic                    last;
    logic [OCC_W-1:0]        occupancy;
  } result_beat_t;

  class deque_mirror;
    logic signed [VAL_W-1:0] ring [Q_DEPTH];
    logic [IDX_W-1:0]        head;
    logic [OCC_W-1:0]        count;
    result_beat_t            expected_beats [$];
    int                      errors;

    function new();
      head   = '0;
      count  = '0;
      errors = 0;
    endfunction

    function logic [IDX_W-1:0] slot(int offset);
      logic [IDX_W-1:0] off;
      off = offset[IDX_W-1:0];
      return head + off;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function void note_op(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] word);
      result_beat_t r;
      r.value     = '0;
      r.status    = ST_OK;
      r.last      = 1'b1;
      r.occupancy = '0;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (count == Q_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            if (op == OP_PUSH_FRONT) begin
              head = head - 1'b1;
              ring[head] = word;
            end else begin
              ring[slot(count)] = word;
            end
            count++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (op == OP_POP_FRONT) begin
              r.value = ring[head];
              head = head + 1'b1;
            end else begin
              r.value = ring[slot(count - 1)];
            end
            count--;
            if (count == 0)
              head = '0;
          end
        end
        OP_DUMP: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            for (int i = 0; i < count; i++) begin
              r.value     = ring[slot(i)];
              r.last      = (i == count - 1);
              r.occupancy = count;
              expected_beats.push_back(r);
            end
            return;
          end
        end
        default: r.status = ST_INVALID;
      endcase
      r.occupancy = count;
      expected_beats.push_back(r);
    endfunction

    task check_beat(result_beat_t got);
      result_beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected result beat value=%0d status=%0d last=%0b occ=%0d",
                         got.value, got.status, got.last, got.occupancy));
        return;
      end
      want = expected_beats.pop_front();
      if (got.value !== want.value)
        report($sformatf("value_out %0d, want %0d", got.value, want.value));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
      if (got.occupancy !== want.occupancy)
        report($sformatf("occupancy %0d, want %0d", got.occupancy, want.occupancy));
    endtask
  endclass

  logic clk;
  logic rst_n;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deque_mirror mirror = new();

  int send_idle_pct;
  int recv_idle_pct;
  int stall_token;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result sink: random backpressure plus a long hold-off when stall_token changes
  initial begin
    int hold_left;
    int stall_seen;
    hold_left  = 0;
    stall_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_seen != stall_token) begin
        stall_seen = stall_token;
        hold_left  = HOLD_LEN;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_beat_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.value     = out_ch.value_out;
        got.status    = out_ch.status;
        got.last      = out_ch.last;
        got.occupancy = out_ch.occupancy;
        mirror.check_beat(got);
      end
      if (in_ch.valid && in_ch.ready)
        mirror.note_op(in_ch.opcode, in_ch.item_value);
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.item_value <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // first lets the last accepted beat reach the mirror, then waits until no result beats are expected
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (mirror.expected_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_word();
    case ($urandom_range(19))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(run_mode_t mode);
    int roll;
    int push_pct;
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL:  push_pct = 78;
      MODE_DRAIN: push_pct = 30;
      default:    push_pct = 55;
    endcase
    if (roll < 4)
      return 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    if (roll < 12)
      return OP_DUMP;
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  task automatic random_runs(input int n_ops);
    int        left;
    int        run_len;
    run_mode_t mode;
    left = n_ops;
    while (left > 0) begin
      mode    = run_mode_t'($urandom_range(2));
      run_len = $urandom_range(6, 20);
      for (int i = 0; i < run_len && left > 0; i++) begin
        send_op(pick_op(mode), pick_word());
        left--;
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_PUSH_FRONT;
    in_ch.item_value <= '0;
    send_idle_pct = 35;
    recv_idle_pct = 79;
    stall_token   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue corners and invalid opcodes
    send_op(OP_DUMP, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    for (int op = OP_BAD_LO; op <= OP_BAD_HI; op++)
      send_op(3'(op), pick_word());
    // extremes at both ends, then dump and drain from both sides
    send_op(OP_PUSH_FRONT, WORD_MIN);
    send_op(OP_PUSH_BACK, WORD_MAX);
    send_op(OP_PUSH_FRONT, '0);
    send_op(OP_PUSH_BACK, -1);
    send_op(OP_PUSH_FRONT, 32'sh5555_5555);
    send_op(OP_PUSH_BACK, 32'shaaaa_aaaa);
    send_op(OP_DUMP, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_DUMP, '0);
    // empty again from the back side
    send_op(OP_PUSH_BACK, pick_word());
    send_op(OP_POP_BACK, '0);
    wait_drained();

    random_runs(PHASE_OPS);
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 35;
    random_runs(PHASE_OPS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long receiver hold-off while pushes keep coming, past full from either end
    stall_token <= stall_token + 1;
    for (int i = 0; i < BURST_OPS; i++)
      send_op($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
    send_op(OP_DUMP, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_DUMP, '0);
    send_op(3'($urandom_range(OP_BAD_LO, OP_BAD_HI)), pick_word());
    random_runs(PHASE_OPS);
    wait_drained();

    repeat (TAIL_WAIT) @(posedge clk);
    if (mirror.expected_beats.size() != 0)
      mirror.report($sformatf("%0d result beats never arrived",
                              mirror.expected_beats.size()));
    if (mirror.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_ram.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/double_ended_queue_unit.sv
tb/tb.sv
